@@ src/wfa_pkg.sv @@
// ----------------------------------------------------------------------------
// Worst-fit allocator package
// Shared request codes, field widths, controller states and the command and
// status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package wfa_pkg;

    // Field widths of the request and result ports.
    localparam int REQ_W  = 2;
    localparam int SLOT_W = 5;
    localparam int AMT_W  = 16;
    localparam int NUM_W  = 6;
    localparam int EXT_W  = 21;
    localparam int INT_W  = 32;

    // Saturation limit of the never-used block total.
    localparam logic [EXT_W-1:0] EXT_MAX = '1;

    // Request codes carried on req_type; the fourth code does nothing.
    localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // latch the request and clear the scan
        logic issue;    // read the slot under the scan pointer and advance
        logic finish;   // apply the update and register the result
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_zero;   // no active blocks
        logic scan_last;    // scan pointer is on the last active slot
    } status_t;

endpackage

@@ src/wfa_ctrl.sv @@
// ----------------------------------------------------------------------------
// Worst-fit allocator controller
// Sequences each request: accept; for allocate or query, one read per active slot and a drain
// step for the last read, if any; then a finish step that updates state and the result.
// ----------------------------------------------------------------------------
module wfa_ctrl
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [wfa_pkg::REQ_W-1:0]  req_type,
    input  wfa_pkg::status_t           status,
    output wfa_pkg::cmd_t              cmd,
    output logic                       busy
);

    wfa_pkg::state_t state_reg;
    wfa_pkg::state_t state_next;
    logic            scans;

    // Allocate and query requests walk the active slots.
    assign scans = (req_type == wfa_pkg::REQ_ALLOC) || (req_type == wfa_pkg::REQ_QUERY);

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wfa_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wfa_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (scans && !status.count_zero)
                    begin
                        state_next = wfa_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = wfa_pkg::ST_FINISH;
                    end
                end
            end
            wfa_pkg::ST_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = wfa_pkg::ST_DRAIN;
                end
            end
            wfa_pkg::ST_DRAIN:
            begin
                state_next = wfa_pkg::ST_FINISH;
            end
            wfa_pkg::ST_FINISH:
            begin
                state_next = wfa_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = wfa_pkg::ST_IDLE;
            end
        endcase
    end

    // Output decode.
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            wfa_pkg::ST_IDLE:
            begin
                busy       = 1'b0;
                cmd.accept = start;
            end
            wfa_pkg::ST_SCAN:
            begin
                cmd.issue = 1'b1;
            end
            wfa_pkg::ST_DRAIN:
            begin
                cmd.issue = 1'b0;
            end
            wfa_pkg::ST_FINISH:
            begin
                cmd.finish = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

@@ src/wfa_datapath.sv @@
// ----------------------------------------------------------------------------
// Worst-fit allocator datapath
// Holds the block size memory, used marks, count register and running
// totals; scans one slot per cycle and registers the result of a request.
// ----------------------------------------------------------------------------
module wfa_datapath
#(
    parameter int NUM_BLOCKS = 32,
    parameter int SIZE_BITS  = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [wfa_pkg::NUM_W-1:0]   cfg_wdata,
    input  logic [wfa_pkg::REQ_W-1:0]   req_type,
    input  logic [wfa_pkg::SLOT_W-1:0]  block_slot,
    input  logic [wfa_pkg::AMT_W-1:0]   amount,
    input  wfa_pkg::cmd_t               cmd,
    output wfa_pkg::status_t            status,
    output logic                        done,
    output logic                        placed,
    output logic [wfa_pkg::NUM_W-1:0]   block_number,
    output logic [wfa_pkg::AMT_W-1:0]   size_before,
    output logic [wfa_pkg::AMT_W-1:0]   leftover,
    output logic [wfa_pkg::INT_W-1:0]   internal_total,
    output logic [wfa_pkg::EXT_W-1:0]   external_total
);

    localparam int IDX_W  = $clog2(NUM_BLOCKS);
    localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
    localparam int CMP_W  = (SIZE_BITS > wfa_pkg::AMT_W) ? SIZE_BITS : wfa_pkg::AMT_W;
    localparam int LIM_W  = (CNT_W > wfa_pkg::NUM_W) ? CNT_W : wfa_pkg::NUM_W;
    localparam int SLT_W  = (CNT_W > wfa_pkg::SLOT_W) ? CNT_W : wfa_pkg::SLOT_W;
    localparam int ESUM_W = ((wfa_pkg::EXT_W > SIZE_BITS) ? wfa_pkg::EXT_W : SIZE_BITS) + 1;
    localparam int ISUM_W = wfa_pkg::INT_W + 1;

    // Configuration and latched request.
    logic [wfa_pkg::NUM_W-1:0]  count_reg;
    logic [wfa_pkg::REQ_W-1:0]  kind_reg;
    logic [wfa_pkg::SLOT_W-1:0] slot_reg;
    logic [wfa_pkg::AMT_W-1:0]  amt_reg;

    // Scan pointer and read stage.
    logic [IDX_W-1:0]     idx_reg;
    logic [SIZE_BITS-1:0] mem [NUM_BLOCKS];
    logic [SIZE_BITS-1:0] rd_size_reg;
    logic                 rd_used_reg;
    logic [IDX_W-1:0]     rd_idx_reg;
    logic                 rd_vld_reg;
    logic                 used_reg [NUM_BLOCKS];

    // Scan results and totals.
    logic                        found_reg;
    logic [IDX_W-1:0]            best_reg;
    logic [SIZE_BITS-1:0]        best_size_reg;
    logic [wfa_pkg::EXT_W-1:0]   ext_reg;
    logic [wfa_pkg::INT_W-1:0]   int_sum_reg;
    logic [wfa_pkg::INT_W-1:0]   int_sum_next;

    // Result registers.
    logic                        done_reg;
    logic                        placed_reg;
    logic [wfa_pkg::NUM_W-1:0]   number_reg;
    logic [wfa_pkg::AMT_W-1:0]   before_reg;
    logic [wfa_pkg::AMT_W-1:0]   left_reg;
    logic [wfa_pkg::INT_W-1:0]   int_out_reg;
    logic [wfa_pkg::EXT_W-1:0]   ext_out_reg;

    // Combinational helpers.
    logic [CNT_W-1:0]     active_cnt;
    logic                 fits;
    logic                 better;
    logic [ESUM_W-1:0]    ext_add;
    logic [wfa_pkg::EXT_W-1:0] ext_sat;
    logic [SIZE_BITS-1:0] rem;
    logic [ISUM_W-1:0]    isum_add;
    logic                 slot_ok;
    logic                 do_load;
    logic                 do_alloc;
    logic [IDX_W-1:0]     wr_addr;
    logic [SIZE_BITS-1:0] wr_data;

    // Active block count, clamped to the table depth.
    assign active_cnt = (LIM_W'(count_reg) > LIM_W'(NUM_BLOCKS))
                        ? CNT_W'(NUM_BLOCKS) : CNT_W'(count_reg);

    assign status.count_zero = (active_cnt == '0);
    assign status.scan_last  = ((CNT_W'(idx_reg) + CNT_W'(1)) == active_cnt);

    // Candidate tests on the slot just read.
    assign fits    = (CMP_W'(rd_size_reg) >= CMP_W'(amt_reg));
    assign better  = !found_reg || (rd_size_reg > best_size_reg);
    assign ext_add = ESUM_W'(ext_reg) + ESUM_W'(rd_size_reg);
    assign ext_sat = (ext_add > ESUM_W'(wfa_pkg::EXT_MAX))
                     ? wfa_pkg::EXT_MAX : wfa_pkg::EXT_W'(ext_add);

    // Allocation update: shrink the chosen block and grow the internal total.
    assign rem      = SIZE_BITS'(CMP_W'(best_size_reg) - CMP_W'(amt_reg));
    assign isum_add = ISUM_W'(int_sum_reg) + ISUM_W'(rem);
    assign do_alloc = cmd.finish && (kind_reg == wfa_pkg::REQ_ALLOC) && found_reg;
    assign int_sum_next = !do_alloc ? int_sum_reg
                        : (isum_add[ISUM_W-1] ? '1 : wfa_pkg::INT_W'(isum_add));

    // Load update: a slot beyond the table is dropped.
    assign slot_ok = (SLT_W'(slot_reg) < SLT_W'(NUM_BLOCKS));
    assign do_load = cmd.finish && (kind_reg == wfa_pkg::REQ_LOAD) && slot_ok;

    // Single write port shared by loads and allocations.
    assign wr_addr = do_load ? IDX_W'(slot_reg) : best_reg;
    assign wr_data = do_load ? SIZE_BITS'(amt_reg) : rem;

    // Configuration register and request latch.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            kind_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
            if (cmd.accept)
            begin
                kind_reg <= req_type;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            slot_reg <= block_slot;
            amt_reg  <= amount;
        end
    end

    // Block size memory with a registered read.
    always_ff @(posedge clk)
    begin
        if (do_load || do_alloc)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.issue)
        begin
            rd_size_reg <= mem[idx_reg];
        end
    end

    // Used marks, cleared at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BLOCKS; i++)
            begin
                used_reg[i] <= 1'b0;
            end
        end
        else if (do_load)
        begin
            used_reg[wr_addr] <= 1'b0;
        end
        else if (do_alloc)
        begin
            used_reg[wr_addr] <= 1'b1;
        end
    end

    // Scan pointer and read stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.issue;
            if (cmd.accept)
            begin
                idx_reg <= '0;
            end
            else if (cmd.issue)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            rd_used_reg <= used_reg[idx_reg];
            rd_idx_reg  <= idx_reg;
        end
    end

    // Running worst-fit pick and never-used sum over the scanned slots.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
            ext_reg   <= '0;
        end
        else if (cmd.accept)
        begin
            found_reg <= 1'b0;
            ext_reg   <= '0;
        end
        else if (rd_vld_reg)
        begin
            if (fits && better)
            begin
                found_reg <= 1'b1;
            end
            if (!rd_used_reg)
            begin
                ext_reg <= ext_sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_vld_reg && fits && better)
        begin
            best_reg      <= rd_idx_reg;
            best_size_reg <= rd_size_reg;
        end
    end

    // Internal fragmentation total.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            int_sum_reg <= '0;
        end
        else
        begin
            int_sum_reg <= int_sum_next;
        end
    end

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            placed_reg  <= do_alloc;
            number_reg  <= do_alloc ? (wfa_pkg::NUM_W'(best_reg) + wfa_pkg::NUM_W'(1)) : '0;
            before_reg  <= do_alloc ? wfa_pkg::AMT_W'(best_size_reg) : '0;
            left_reg    <= do_alloc ? wfa_pkg::AMT_W'(rem) : '0;
            int_out_reg <= int_sum_next;
            ext_out_reg <= (kind_reg == wfa_pkg::REQ_QUERY) ? ext_reg : '0;
        end
    end

    assign done           = done_reg;
    assign placed         = placed_reg;
    assign block_number   = number_reg;
    assign size_before    = before_reg;
    assign leftover       = left_reg;
    assign internal_total = int_out_reg;
    assign external_total = ext_out_reg;

endmodule

@@ src/worst_fit_allocator.sv @@
// ----------------------------------------------------------------------------
// Worst-fit allocator
// Top level: controller plus datapath over a table of free-block sizes.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Every request gives
// exactly one result, shown for one cycle with done high; the result cannot
// be held off, so it must be captured in that cycle. A load or an unknown
// request goes from acceptance straight to the finish state. An allocate or
// query request first scans the N active slots, where N is the active block
// count clamped to the table depth, one slot per cycle since the block size
// memory has one read port, then drains; with N zero it skips both. A new
// request may be started in the cycle its predecessor's result is shown.
// Write block_count through cfg_we and cfg_wdata only while busy is low.
module worst_fit_allocator
#(
    parameter int NUM_BLOCKS = 32,
    parameter int SIZE_BITS  = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [wfa_pkg::NUM_W-1:0]   cfg_wdata,
    input  logic                        start,
    output logic                        busy,
    input  logic [wfa_pkg::REQ_W-1:0]   req_type,
    input  logic [wfa_pkg::SLOT_W-1:0]  block_slot,
    input  logic [wfa_pkg::AMT_W-1:0]   amount,
    output logic                        done,
    output logic                        placed,
    output logic [wfa_pkg::NUM_W-1:0]   block_number,
    output logic [wfa_pkg::AMT_W-1:0]   size_before,
    output logic [wfa_pkg::AMT_W-1:0]   leftover,
    output logic [wfa_pkg::INT_W-1:0]   internal_total,
    output logic [wfa_pkg::EXT_W-1:0]   external_total
);

    wfa_pkg::cmd_t    cmd;
    wfa_pkg::status_t status;

    // Request sequencer.
    wfa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy)
    );

    // Storage, scan and result registers.
    wfa_datapath
    #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    )
    u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .req_type       (req_type),
        .block_slot     (block_slot),
        .amount         (amount),
        .cmd            (cmd),
        .status         (status),
        .done           (done),
        .placed         (placed),
        .block_number   (block_number),
        .size_before    (size_before),
        .leftover       (leftover),
        .internal_total (internal_total),
        .external_total (external_total)
    );

    // A result is only shown once the sequencer is back in idle.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while busy");

    // An accepted request always makes the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accepted request did not start");

    // A result that placed nothing carries no block, size or leftover.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !placed) |-> (block_number == '0 && size_before == '0 && leftover == '0))
        else $error("unplaced result carries allocation fields");

    // The internal total never falls across back-to-back results (next request started on done).
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(done, 2)) |-> (internal_total >= $past(internal_total, 2)))
        else $error("internal total decreased");

endmodule
